[sv/rtt_pkg.sv]
// Shared types, codes and default sizes for the request tag table.
`default_nettype none

package rtt_pkg;

    // Default sizes of the table.
    localparam int SLOTS_DEF    = 32;
    localparam int ID_BITS_DEF  = 10;
    localparam int GEN_BITS_DEF = 26;

    // Fixed field widths of the stream payload.
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int PEER_ID_W = 10;
    localparam int PSLOT_W   = 5;
    localparam int TAG_W     = 32;
    localparam int TAG_GEN_W = 26;
    localparam int TAG_GEN_LSB = 6;

    // Packed widths of the data buses, padded to whole bytes.
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    // Item kinds on the input stream.
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_REPLY  = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_RSVD   = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BAD_TAG  = 2'd2,
        STAT_MISMATCH = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

[sv/rtt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/request_tag_table_unit.sv]
// Top level of the request tag table: slot allocation, reply lookup and cancel.
//
// Usage:
// Items enter on the s_ stream; kind rides in s_tuser, and s_tdata carries
// peer_id, peer_slot and tag. Allocate takes the lowest free slot, bumps its
// generation and returns tag = generation<<6 | slot<<1 | 1. Reply checks a
// tag against the slot's occupancy and generation, returns the stored
// requester id and slot and frees the slot. Cancel frees a slot whose stored
// id and slot match the given ones. Every beat in yields one result beat on
// the m_ stream, with the status in m_tuser.
// Timing: the idle state accepts a beat and reads the slot's entry from the
// slot memory; the read state then checks the entry, writes it back on an
// allocate and loads the output register. The block takes no new item until
// the read state has finished the current one.
// Reset empties the table, clears all generations to zero and drops any
// pending result. When the receiver stalls, the result is held in the output
// register and the block finishes its current item only once that register
// drains; s_tready stays low until then.
`default_nettype none

module request_tag_table_unit
    import rtt_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int ID_BITS  = ID_BITS_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // s_tdata from bit 0: peer_id[9:0], peer_slot[14:10], tag[46:15], zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: kind[1:0]
    input  wire logic [KIND_W-1:0]   s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // m_tdata from bit 0: out_tag[31:0], owner_id[41:32], owner_slot[46:42],
    // slot[51:47], zero pad
    output logic [M_DATA_W-1:0]      m_tdata,
    // m_tuser: status[1:0]
    output logic [STATUS_W-1:0]      m_tuser
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W = GEN_BITS + ID_BITS + PSLOT_W;

    // Input payload fields.
    logic [PEER_ID_W-1:0] in_peer_id;
    logic [PSLOT_W-1:0]   in_peer_slot;
    logic [TAG_W-1:0]     in_tag;
    logic                 s_accept;

    assign in_peer_id   = s_tdata[PEER_ID_W-1:0];
    assign in_peer_slot = s_tdata[PEER_ID_W+PSLOT_W-1:PEER_ID_W];
    assign in_tag       = s_tdata[PEER_ID_W+PSLOT_W+TAG_W-1:PEER_ID_W+PSLOT_W];
    assign s_accept     = s_tvalid && s_tready;

    // Control and held item.
    state_t               state_reg, state_next;
    logic [SLOTS-1:0]     free_mask_reg, free_mask_next;
    logic [SLOTS-1:0]     gen_valid_reg, gen_valid_next;
    kind_t                kind_reg;
    logic [PEER_ID_W-1:0] pid_reg;
    logic [PSLOT_W-1:0]   pslot_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [SLOT_W-1:0]    slot_reg;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    status_t              status_reg, status_next;
    logic [TAG_W-1:0]     out_tag_reg, out_tag_next;
    logic [PEER_ID_W-1:0] owner_id_reg, owner_id_next;
    logic [PSLOT_W-1:0]   owner_slot_reg, owner_slot_next;
    logic [PSLOT_W-1:0]   slot_out_reg, slot_out_next;

    // Lowest free slot.
    logic [SLOT_W-1:0] alloc_slot;
    logic [PSLOT_W-1:0] tag_slot_in;
    logic [SLOT_W-1:0] read_slot;

    always_comb
    begin
        alloc_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_mask_reg[i])
            begin
                alloc_slot = SLOT_W'(i);
            end
        end
    end

    assign tag_slot_in = in_tag[PSLOT_W:1];
    assign read_slot   = (kind_t'(s_tuser) == KIND_ALLOC) ? alloc_slot
                                                          : tag_slot_in[SLOT_W-1:0];

    // Slot memory: generation, owner id and owner slot per entry.
    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [GEN_BITS-1:0]   ram_gen;
    logic [ID_BITS-1:0]    ram_pid;
    logic [PSLOT_W-1:0]    ram_pslot;

    rtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (read_slot),
        .rdata (ram_rdata)
    );

    assign ram_gen   = ram_rdata[ENTRY_W-1:ID_BITS+PSLOT_W];
    assign ram_pid   = ram_rdata[ID_BITS+PSLOT_W-1:PSLOT_W];
    assign ram_pslot = ram_rdata[PSLOT_W-1:0];

    // Decode of the held item against its entry.
    logic                commit;
    logic                full;
    logic [GEN_BITS-1:0] gen_cur;
    logic [GEN_BITS-1:0] gen_new;
    logic [PSLOT_W-1:0]  held_tag_slot;
    logic                in_range;
    logic                occupied;
    logic [SLOTS-1:0]    slot_bit;

    assign commit        = (state_reg == ST_READ) && (!m_valid_reg || m_tready);
    assign full          = (free_mask_reg == '0);
    assign gen_cur       = gen_valid_reg[slot_reg] ? ram_gen : '0;
    assign gen_new       = gen_cur + GEN_BITS'(1);
    assign held_tag_slot = tag_reg[PSLOT_W:1];
    assign in_range      = ({1'b0, held_tag_slot} < (PSLOT_W + 1)'(SLOTS));
    assign occupied      = in_range && !free_mask_reg[slot_reg];
    assign slot_bit      = SLOTS'(1) << slot_reg;
    assign ram_wdata     = {gen_new, ID_BITS'(pid_reg), pslot_reg};

    // Sequencer, table update and result.
    always_comb
    begin
        state_next      = state_reg;
        free_mask_next  = free_mask_reg;
        gen_valid_next  = gen_valid_reg;
        ram_we          = 1'b0;
        m_valid_next    = m_valid_reg && !m_tready;
        status_next     = status_reg;
        out_tag_next    = out_tag_reg;
        owner_id_next   = owner_id_reg;
        owner_slot_next = owner_slot_reg;
        slot_out_next   = slot_out_reg;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (commit)
                begin
                    state_next      = ST_IDLE;
                    m_valid_next    = 1'b1;
                    status_next     = STAT_BAD_TAG;
                    out_tag_next    = '0;
                    owner_id_next   = '0;
                    owner_slot_next = '0;
                    slot_out_next   = '0;
                    unique case (kind_reg)
                        KIND_ALLOC:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next    = STAT_OK;
                                ram_we         = 1'b1;
                                gen_valid_next = gen_valid_reg | slot_bit;
                                free_mask_next = free_mask_reg & ~slot_bit;
                                out_tag_next   = {TAG_GEN_W'(gen_new),
                                                  PSLOT_W'(slot_reg), 1'b1};
                                slot_out_next  = PSLOT_W'(slot_reg);
                            end
                        end
                        KIND_REPLY:
                        begin
                            if (tag_reg[0] && occupied &&
                                (tag_reg[TAG_W-1:TAG_GEN_LSB] == TAG_GEN_W'(gen_cur)))
                            begin
                                status_next     = STAT_OK;
                                free_mask_next  = free_mask_reg | slot_bit;
                                owner_id_next   = PEER_ID_W'(ram_pid);
                                owner_slot_next = ram_pslot;
                                slot_out_next   = PSLOT_W'(slot_reg);
                            end
                        end
                        KIND_CANCEL:
                        begin
                            if (occupied && (ram_pid == ID_BITS'(pid_reg)) &&
                                (ram_pslot == pslot_reg))
                            begin
                                status_next    = STAT_OK;
                                free_mask_next = free_mask_reg | slot_bit;
                                slot_out_next  = PSLOT_W'(slot_reg);
                            end
                            else
                            begin
                                status_next = STAT_MISMATCH;
                            end
                        end
                        KIND_RSVD:
                        begin
                            status_next = STAT_BAD_TAG;
                        end
                    endcase
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_mask_reg <= '1;
            gen_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_mask_reg <= free_mask_next;
            gen_valid_reg <= gen_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Held item, captured on each accepted beat.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg  <= kind_t'(s_tuser);
            pid_reg   <= in_peer_id;
            pslot_reg <= in_peer_slot;
            tag_reg   <= in_tag;
            slot_reg  <= read_slot;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        out_tag_reg    <= out_tag_next;
        owner_id_reg   <= owner_id_next;
        owner_slot_reg <= owner_slot_next;
        slot_out_reg   <= slot_out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {(M_DATA_W - TAG_W - PEER_ID_W - 2 * PSLOT_W)'(0),
                       slot_out_reg, owner_slot_reg, owner_id_reg, out_tag_reg};

    // An allocate only ever hands out a slot that was free.
    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && kind_reg == KIND_ALLOC && !full) |-> free_mask_reg[slot_reg])
        else $error("allocate picked an occupied slot");

    // After a granted allocate the slot is marked occupied.
    a_alloc_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && kind_reg == KIND_ALLOC && !full) |=> !free_mask_reg[$past(slot_reg)])
        else $error("allocated slot still marked free");

    // The free mask only moves when an item completes.
    a_mask_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(free_mask_reg))
        else $error("free mask changed outside item completion");

    // Every accepted beat is followed by the memory-read cycle.
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_READ))
        else $error("accepted beat did not enter the read cycle");

    // A completed item always leaves a result in the output register.
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_valid_reg)
        else $error("completed item produced no result");

endmodule

`default_nettype wire

[test/request_tag_table_unit_tb.sv]
// Self-checking testbench for the request tag table: slot allocation, reply lookup and cancel.

module request_tag_table_unit_tb;
    import rtt_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_ITEMS = 1025;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 20;
    localparam int FILL_BURST   = 36;

    // One item offered to the table.
    typedef struct {
        kind_t                kind;
        logic [PEER_ID_W-1:0] peer_id;
        logic [PSLOT_W-1:0]   peer_slot;
        logic [TAG_W-1:0]     tag;
    } request_t;

    // One result beat coming back from the table.
    typedef struct {
        status_t              status;
        logic [TAG_W-1:0]     out_tag;
        logic [PEER_ID_W-1:0] owner_id;
        logic [PSLOT_W-1:0]   owner_slot;
        logic [PSLOT_W-1:0]   slot;
    } outcome_t;

    // Shadow copy of the slot table and the results it predicts, oldest first.
    class tag_ledger;
        bit [SLOTS_DEF-1:0] free_mask;
        bit [TAG_GEN_W-1:0] gen_tbl [SLOTS_DEF];
        bit [PEER_ID_W-1:0] owner_tbl [SLOTS_DEF];
        bit [PSLOT_W-1:0]   oslot_tbl [SLOTS_DEF];
        outcome_t           awaited [$];
        int                 faults;

        function new();
            free_mask = '1;
            foreach (gen_tbl[i])
            begin
                gen_tbl[i]   = '0;
                owner_tbl[i] = '0;
                oslot_tbl[i] = '0;
            end
            faults = 0;
        endfunction

        // Apply one accepted item to the shadow table and queue its result.
        function void record_request(request_t r);
            outcome_t o;
            int       s;
            int       pick;
            o.status     = STAT_OK;
            o.out_tag    = '0;
            o.owner_id   = '0;
            o.owner_slot = '0;
            o.slot       = '0;
            s = int'(r.tag[5:1]);
            case (r.kind)
                KIND_ALLOC:
                begin
                    pick = -1;
                    for (int k = SLOTS_DEF - 1; k >= 0; k--)
                        if (free_mask[k])
                            pick = k;
                    if (pick < 0)
                        o.status = STAT_FULL;
                    else
                    begin
                        free_mask[pick] = 1'b0;
                        gen_tbl[pick]   = gen_tbl[pick] + 1'b1;
                        owner_tbl[pick] = r.peer_id;
                        oslot_tbl[pick] = r.peer_slot;
                        o.out_tag = {gen_tbl[pick], 5'(pick), 1'b1};
                        o.slot    = 5'(pick);
                    end
                end
                KIND_REPLY:
                begin
                    if (!r.tag[0] || free_mask[s] || r.tag[TAG_W-1:TAG_GEN_LSB] != gen_tbl[s])
                        o.status = STAT_BAD_TAG;
                    else
                    begin
                        free_mask[s] = 1'b1;
                        o.owner_id   = owner_tbl[s];
                        o.owner_slot = oslot_tbl[s];
                        o.slot       = 5'(s);
                    end
                end
                KIND_CANCEL:
                begin
                    if (free_mask[s] || owner_tbl[s] != r.peer_id ||
                        oslot_tbl[s] != r.peer_slot)
                        o.status = STAT_MISMATCH;
                    else
                    begin
                        free_mask[s] = 1'b1;
                        o.slot       = 5'(s);
                    end
                end
                default:
                    o.status = STAT_BAD_TAG;
            endcase
            awaited.push_back(o);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                faults++;
                if (faults <= 10)
                    $display("Mismatch in %s: expected %h, got %h", field, want, got);
            end
        endfunction

        // Check one result beat against the oldest prediction.
        function void check_outcome(outcome_t got);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("Result beat with no item outstanding: status %h, tag %h",
                             got.status, got.out_tag);
                return;
            end
            want = awaited.pop_front();
            compare("status", want.status, got.status);
            compare("out_tag", want.out_tag, got.out_tag);
            compare("owner_id", want.owner_id, got.owner_id);
            compare("owner_slot", want.owner_slot, got.owner_slot);
            compare("slot", want.slot, got.slot);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    tag_ledger ledger;
    int        cycle_count = 0;
    logic      hold_rx = 1'b0;
    bit        start_hold = 1'b0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;
    int        stall_left = 0;
    int        rx_roll;
    outcome_t  rx_beat;

    request_tag_table_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: take accepted beats, then choose the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_beat.status     = status_t'(m_tuser);
            rx_beat.out_tag    = m_tdata[31:0];
            rx_beat.owner_id   = m_tdata[41:32];
            rx_beat.owner_slot = m_tdata[46:42];
            rx_beat.slot       = m_tdata[51:47];
            ledger.check_outcome(rx_beat);
        end
        if (cycle_count % 256 == 0)
            rx_calm = ($urandom_range(3) == 0);
        if (hold_rx)
            m_tready <= 1'b0;
        else if (rx_calm)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_roll = $urandom_range(99);
            if (rx_roll < 4)
                stall_left = $urandom_range(8, 40);
            m_tready <= (rx_roll >= 25);
        end
    end

    // Long receiver hold-off so that the table backs up and stalls its input.
    initial
    begin
        wait (start_hold);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    function automatic request_t mk(kind_t k, int pid, int ps, logic [TAG_W-1:0] tg);
        request_t r;
        r.kind      = k;
        r.peer_id   = PEER_ID_W'(pid);
        r.peer_slot = PSLOT_W'(ps);
        r.tag       = tg;
        return r;
    endfunction

    // Tag that a reply to slot s must carry right now.
    function automatic logic [TAG_W-1:0] live_tag(int s);
        return {ledger.gen_tbl[s], 5'(s), 1'b1};
    endfunction

    // Random occupied (busy = 1) or free (busy = 0) slot, or -1 if none.
    function automatic int pick_slot(bit busy);
        int cand [$];
        for (int i = 0; i < SLOTS_DEF; i++)
            if (ledger.free_mask[i] != busy)
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    // Mostly well-formed traffic against live slots, with some stale and broken items.
    function automatic request_t random_request(int alloc_pct);
        request_t q;
        int       s;
        int       f;
        int       roll;
        q = mk(KIND_ALLOC, $urandom_range(1023), $urandom_range(31), $urandom());
        s = pick_slot(1'b1);
        if ($urandom_range(99) < alloc_pct || s < 0)
            return q;
        roll = $urandom_range(99);
        if (roll < 45)
        begin
            q.kind = KIND_REPLY;
            q.tag  = live_tag(s);
        end
        else if (roll < 75)
        begin
            q.kind      = KIND_CANCEL;
            q.peer_id   = ledger.owner_tbl[s];
            q.peer_slot = ledger.oslot_tbl[s];
            q.tag[5:1]  = 5'(s);
        end
        else
        begin
            case ($urandom_range(6))
                0:
                begin
                    // Reply to a slot that has already been released.
                    f = pick_slot(1'b0);
                    q.kind = KIND_REPLY;
                    if (f >= 0)
                        q.tag = live_tag(f);
                end
                1:
                begin
                    q.kind = KIND_REPLY;
                    q.tag  = live_tag(s) + (TAG_W'($urandom_range(1, 3)) << TAG_GEN_LSB);
                end
                2:
                begin
                    q.kind = KIND_REPLY;
                    q.tag  = live_tag(s) & ~TAG_W'(1);
                end
                3:
                    q.kind = KIND_REPLY;
                4:
                begin
                    q.kind      = KIND_CANCEL;
                    q.peer_id   = ledger.owner_tbl[s] ^ (PEER_ID_W'(1) << $urandom_range(9));
                    q.peer_slot = ledger.oslot_tbl[s];
                    q.tag[5:1]  = 5'(s);
                end
                5:
                begin
                    q.kind      = KIND_CANCEL;
                    q.peer_id   = ledger.owner_tbl[s];
                    q.peer_slot = ledger.oslot_tbl[s] ^ (PSLOT_W'(1) << $urandom_range(4));
                    q.tag[5:1]  = 5'(s);
                end
                default:
                    q.kind = KIND_RSVD;
            endcase
        end
        return q;
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (hold_rx || start_hold && !hold_rx && cycle_count < 0 || tx_calm || roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one beat and record it once the table takes it.
    task automatic send_req(request_t r);
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= S_DATA_W'({r.tag, r.peer_slot, r.peer_id});
        do
            @(posedge clk);
        while (!s_tready);
        ledger.record_request(r);
    endtask

    task automatic idle_for(int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        while (ledger.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        ledger = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, reserved kind, field extremes, stale and forged tags.
        send_req(mk(KIND_REPLY, 0, 0, 32'h1));
        send_req(mk(KIND_CANCEL, 0, 0, 32'h0));
        send_req(mk(KIND_RSVD, 1023, 31, '1));
        send_req(mk(KIND_RSVD, 0, 0, '0));
        send_req(mk(KIND_ALLOC, 0, 0, '0));
        send_req(mk(KIND_ALLOC, 1023, 31, '1));
        send_req(mk(KIND_ALLOC, 10'h155, 5'h15, 32'h5555_5555));
        send_req(mk(KIND_REPLY, 0, 0, live_tag(1) & ~TAG_W'(1)));
        send_req(mk(KIND_REPLY, 0, 0, live_tag(1) + (TAG_W'(1) << TAG_GEN_LSB)));
        send_req(mk(KIND_REPLY, 0, 0, live_tag(1)));
        send_req(mk(KIND_REPLY, 0, 0, live_tag(1)));
        send_req(mk(KIND_REPLY, 1023, 31, 32'hFFFF_FFFF));
        send_req(mk(KIND_CANCEL, 1, 0, 32'h0));
        send_req(mk(KIND_CANCEL, 0, 31, 32'h0));
        // Cancel ignores bit 0 and the generation bits.
        send_req(mk(KIND_CANCEL, 0, 0, 32'hFFFF_FFC0));
        send_req(mk(KIND_CANCEL, 0, 0, 32'h0));
        send_req(mk(KIND_ALLOC, 512, 16, '0));
        send_req(mk(KIND_REPLY, 0, 0, live_tag(0) - (TAG_W'(1) << TAG_GEN_LSB)));
        send_req(mk(KIND_REPLY, 0, 0, live_tag(0)));
        send_req(mk(KIND_CANCEL, 10'h155, 5'h15, 32'h0000_0005));
        send_req(mk(KIND_ALLOC, 10'h2AA, 5'h0A, 32'hAAAA_AAAA));
        send_req(mk(KIND_CANCEL, $urandom_range(1023), $urandom_range(31), 32'h0000_003E));

        // Random part: a fill burst to reach a full table, then filling and draining phases.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 128 == 0)
                tx_calm = ($urandom_range(3) == 0);
            if (n == 300)
                start_hold = 1'b1;
            if (n == 600)
            begin
                idle_for(1);
                drain_results();
            end
            if (n < FILL_BURST)
                send_req(random_request(100));
            else
                send_req(random_request(((n / 96) % 2 == 0) ? 60 : 25));
            idle_for(gap_len());
        end

        // Wind down: let every result arrive, then watch for strays.
        idle_for(1);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.faults == 0 && ledger.awaited.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
